// ----- rtl/wpsp_pkg.sv -----
`timescale 1ns / 1ps

package wpsp_pkg;

    // Stream widths and result field positions in m_tdata
    localparam int S_TDATA_W   = 8;
    localparam int M_TDATA_W   = 56;
    localparam int SMP_LSB     = 0;
    localparam int SMP_MSB     = 15;
    localparam int CHAN_LSB    = 16;
    localparam int CHAN_MSB    = 17;
    localparam int BITS_LSB    = 18;
    localparam int BITS_MSB    = 22;
    localparam int RATE_LSB    = 23;
    localparam int RATE_MSB    = 54;

    // Chunk tags as they read after four little-endian bytes
    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;

    localparam logic [31:0] FMT_MIN_LEN  = 32'd16;
    localparam logic [31:0] OFFSET_MAX   = 32'hFFFF_FFFF;
    localparam logic [4:0]  BITS_NARROW  = 5'd8;
    localparam logic [4:0]  BITS_WIDE    = 5'd16;

    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_ERROR  = 1'b1;

    typedef enum logic [3:0] {
        PH_RIFF      = 4'd0,
        PH_SIZE      = 4'd1,
        PH_WAVE      = 4'd2,
        PH_HDR_FMT   = 4'd3,
        PH_SKIP_FMT  = 4'd4,
        PH_FMT_A     = 4'd5,
        PH_FMT_RATE  = 4'd6,
        PH_FMT_B     = 4'd7,
        PH_FMT_C     = 4'd8,
        PH_FMT_TAIL  = 4'd9,
        PH_HDR_DATA  = 4'd10,
        PH_SKIP_DATA = 4'd11,
        PH_DATA      = 4'd12,
        PH_DONE      = 4'd13,
        PH_ERR       = 4'd14
    } phase_t;

endpackage

// ----- rtl/wave_pcm_stream_parser_top.sv -----
`timescale 1ns / 1ps

// WAVE PCM stream parser.
// Slave channel: one file byte per transfer in s_tdata[7:0]; s_tuser = 1 marks
// the first byte of a new file and restarts the parser on that byte.
// Master channel: at most one result per input byte. m_tuser is the result
// kind (0 sample, 1 corrupt or unsupported file), m_tlast flags the sample
// that consumes the final bytes of the data chunk. After an error, bytes are
// dropped silently until the next start-of-file byte.
// Pipeline: an input register, then one pass of parse logic into the output
// register. Each accepted byte is parsed from the input register, and any result
// is registered into the output register when that register is free. One byte
// is taken every cycle while s_tready is high; the input register advances
// whenever the output register is empty or being drained, so s_tready drops
// only while a result is stalled and the input register is full.
// Reset (aresetn low, synchronous) clears both valid flags and the parser
// state but not the pending frame bytes; the parser then expects the RIFF tag.
// While m_tready is low the result holds in the output register, one more byte
// waits in the input register, and further transfers stall.
module wave_pcm_stream_parser_top (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [wpsp_pkg::S_TDATA_W-1:0] s_tdata,  // [7:0] data_byte
    input  logic                          s_tuser,  // [0] start_of_file
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [15:0] sample_value, [17:16] channel_count, [22:18] bits_per_sample,
    // [54:23] sample_rate, [55] zero fill
    output logic [wpsp_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                          m_tuser,  // [0] result_kind
    output logic                          m_tlast   // last_sample
);
    import wpsp_pkg::*;

    // Input register
    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        in_sof_reg;

    // Parser state
    phase_t      phase_reg, phase_next;
    logic [2:0]  cnt_reg, cnt_next;
    logic [31:0] shift_reg, shift_next;
    logic [31:0] offset_reg, offset_next;
    logic [31:0] riff_reg, riff_next;
    logic [31:0] remain_reg, remain_next;
    logic [1:0]  chan_reg, chan_next;
    logic        wide_reg, wide_next;
    logic [31:0] rate_reg, rate_next;
    logic [23:0] pend_reg, pend_next;

    // Output register
    logic        m_valid_reg, m_valid_next;
    logic [15:0] m_smp_reg;
    logic [1:0]  m_chan_reg;
    logic        m_wide_reg;
    logic [31:0] m_rate_reg;
    logic        m_kind_reg;
    logic        m_last_reg;

    logic        advance;
    logic        step;

    // Current state, with a start-of-file byte seeing the reset values
    phase_t      phase_c;
    logic [2:0]  cnt_c;
    logic [31:0] shift_c, offset_c, riff_c, remain_c, rate_c;
    logic [1:0]  chan_c;
    logic        wide_c;

    logic [31:0] shift_in;
    logic [31:0] offset_inc;
    logic [31:0] remain_dec;
    logic [2:0]  cnt_inc;
    logic [31:0] wanted;
    logic [2:0]  need;

    logic        emit;
    logic        res_kind;
    logic [15:0] res_smp;
    logic        res_last;

    // Sample arithmetic
    logic [7:0]         b0, b1, b2, b3;
    logic signed [7:0]  d0, d1;
    logic signed [16:0] mono8;
    logic signed [8:0]  sum8;
    logic signed [15:0] a16, c16;
    logic [15:0]        ha, hc;
    logic [15:0]        sample;

    assign advance  = !m_valid_reg || m_tready;
    assign step     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
            in_sof_reg  <= s_tuser;
        end
    end

    // Frame bytes: earlier bytes come from the pending register
    always_comb begin
        b0    = (cnt_c == 3'd0) ? in_byte_reg : pend_reg[7:0];
        b1    = (cnt_c == 3'd1) ? in_byte_reg : pend_reg[15:8];
        b2    = (cnt_c == 3'd2) ? in_byte_reg : pend_reg[23:16];
        b3    = in_byte_reg;
        d0    = {~b0[7], b0[6:0]};
        d1    = {~b1[7], b1[6:0]};
        mono8 = (17'(d0) <<< 8) + 17'(d0);
        sum8  = 9'(d0) + 9'(d1);
        a16   = {b1, b0};
        c16   = {b3, b2};
        // Halve toward zero: add one back for odd negatives
        ha    = 16'(a16 >>> 1) + {15'd0, a16[15] & a16[0]};
        hc    = 16'(c16 >>> 1) + {15'd0, c16[15] & c16[0]};
        case ({chan_c == 2'd2, wide_c})
            2'b00:   sample = (mono8[16] != mono8[15]) ? 16'h8000 : mono8[15:0];
            2'b10:   sample = {sum8, 7'd0};
            2'b01:   sample = a16;
            2'b11:   sample = ha + hc;
            default: sample = 16'd0;
        endcase
    end

    always_comb begin
        phase_c  = in_sof_reg ? PH_RIFF : phase_reg;
        cnt_c    = in_sof_reg ? 3'd0 : cnt_reg;
        shift_c  = in_sof_reg ? 32'd0 : shift_reg;
        offset_c = in_sof_reg ? 32'd0 : offset_reg;
        riff_c   = in_sof_reg ? 32'd0 : riff_reg;
        remain_c = in_sof_reg ? 32'd0 : remain_reg;
        chan_c   = in_sof_reg ? 2'd1 : chan_reg;
        wide_c   = in_sof_reg ? 1'b0 : wide_reg;
        rate_c   = in_sof_reg ? 32'd0 : rate_reg;

        shift_in   = {in_byte_reg, shift_c[31:8]};
        offset_inc = (offset_c == OFFSET_MAX) ? offset_c : offset_c + 32'd1;
        remain_dec = remain_c - 32'd1;
        cnt_inc    = cnt_c + 3'd1;
        wanted     = (phase_c == PH_HDR_FMT) ? TAG_FMT : TAG_DATA;
        case ({chan_c == 2'd2, wide_c})
            2'b00:   need = 3'd1;
            2'b11:   need = 3'd4;
            default: need = 3'd2;
        endcase

        phase_next  = phase_c;
        cnt_next    = cnt_c;
        shift_next  = shift_c;
        offset_next = offset_inc;
        riff_next   = riff_c;
        remain_next = remain_c;
        chan_next   = chan_c;
        wide_next   = wide_c;
        rate_next   = rate_c;
        pend_next   = pend_reg;

        emit     = 1'b0;
        res_kind = KIND_ERROR;
        res_smp  = 16'd0;
        res_last = 1'b0;

        case (phase_c)
            PH_RIFF, PH_SIZE, PH_WAVE, PH_FMT_A, PH_FMT_RATE, PH_FMT_B, PH_FMT_C: begin
                shift_next = shift_in;
                cnt_next   = cnt_inc;
                if (cnt_inc >= 3'd4) begin
                    cnt_next = 3'd0;
                    case (phase_c)
                        PH_RIFF: begin
                            if (shift_in != TAG_RIFF) begin
                                emit = 1'b1;
                            end else begin
                                phase_next = PH_SIZE;
                            end
                        end
                        PH_SIZE: begin
                            riff_next  = shift_in;
                            phase_next = PH_WAVE;
                        end
                        PH_WAVE: begin
                            if (shift_in != TAG_WAVE) begin
                                emit = 1'b1;
                            end else begin
                                phase_next = PH_HDR_FMT;
                            end
                        end
                        PH_FMT_A: begin
                            if (shift_in[31:16] != 16'd1 && shift_in[31:16] != 16'd2) begin
                                emit = 1'b1;
                            end else begin
                                chan_next  = shift_in[17:16];
                                phase_next = PH_FMT_RATE;
                            end
                        end
                        PH_FMT_RATE: begin
                            rate_next  = shift_in;
                            phase_next = PH_FMT_B;
                        end
                        PH_FMT_B: begin
                            phase_next = PH_FMT_C;
                        end
                        default: begin
                            if (shift_in[31:16] == 16'(BITS_NARROW)) begin
                                wide_next = 1'b0;
                            end else if (shift_in[31:16] == 16'(BITS_WIDE)) begin
                                wide_next = 1'b1;
                            end else begin
                                emit = 1'b1;
                            end
                            phase_next = (remain_c == 32'd0) ? PH_HDR_DATA : PH_FMT_TAIL;
                        end
                    endcase
                end
            end
            PH_HDR_FMT, PH_HDR_DATA: begin
                shift_next = shift_in;
                cnt_next   = cnt_inc;
                if (cnt_c == 3'd3) begin
                    // Tag complete; hold it in the remaining-count register
                    remain_next = shift_in;
                end else if (cnt_c == 3'd7) begin
                    cnt_next = 3'd0;
                    if (remain_c == wanted) begin
                        if (phase_c == PH_HDR_FMT) begin
                            if (shift_in < FMT_MIN_LEN) begin
                                emit = 1'b1;
                            end else begin
                                remain_next = shift_in - FMT_MIN_LEN;
                                phase_next  = PH_FMT_A;
                            end
                        end else begin
                            remain_next = shift_in;
                            phase_next  = (shift_in == 32'd0) ? PH_DONE : PH_DATA;
                        end
                    end else if ({1'b0, offset_inc} + {1'b0, shift_in} >= {1'b0, riff_c}) begin
                        emit = 1'b1;
                    end else begin
                        remain_next = shift_in;
                        if (shift_in != 32'd0) begin
                            phase_next = (phase_c == PH_HDR_FMT) ? PH_SKIP_FMT : PH_SKIP_DATA;
                        end
                    end
                end
            end
            PH_SKIP_FMT, PH_SKIP_DATA, PH_FMT_TAIL: begin
                remain_next = remain_dec;
                if (remain_dec == 32'd0) begin
                    phase_next = (phase_c == PH_SKIP_FMT) ? PH_HDR_FMT : PH_HDR_DATA;
                end
            end
            PH_DATA: begin
                remain_next = remain_dec;
                if ({1'b0, cnt_c} + 4'd1 >= {1'b0, need}) begin
                    emit     = 1'b1;
                    res_kind = KIND_SAMPLE;
                    res_smp  = sample;
                    res_last = (remain_dec == 32'd0);
                    cnt_next = 3'd0;
                    if (remain_dec == 32'd0) begin
                        phase_next = PH_DONE;
                    end
                end else begin
                    case (cnt_c)
                        3'd0:    pend_next = {16'd0, in_byte_reg};
                        3'd1:    pend_next[15:8] = in_byte_reg;
                        3'd2:    pend_next[23:16] = in_byte_reg;
                        default: pend_next = pend_reg;
                    endcase
                    cnt_next = cnt_inc;
                    // Data ran out inside a frame
                    if (remain_dec == 32'd0) begin
                        emit = 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase

        if (emit && res_kind == KIND_ERROR) begin
            phase_next = PH_ERR;
        end

        m_valid_next = m_valid_reg && !m_tready;
        if (advance) begin
            m_valid_next = in_valid_reg && emit;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_RIFF;
            cnt_reg     <= 3'd0;
            shift_reg   <= 32'd0;
            offset_reg  <= 32'd0;
            riff_reg    <= 32'd0;
            remain_reg  <= 32'd0;
            chan_reg    <= 2'd1;
            wide_reg    <= 1'b0;
            rate_reg    <= 32'd0;
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (step) begin
                phase_reg  <= phase_next;
                cnt_reg    <= cnt_next;
                shift_reg  <= shift_next;
                offset_reg <= offset_next;
                riff_reg   <= riff_next;
                remain_reg <= remain_next;
                chan_reg   <= chan_next;
                wide_reg   <= wide_next;
                rate_reg   <= rate_next;
            end
        end
    end

    // Payload registers: no reset
    always_ff @(posedge aclk) begin
        if (step) begin
            pend_reg <= pend_next;
        end
        if (step && emit) begin
            m_smp_reg  <= res_smp;
            m_chan_reg <= chan_c;
            m_wide_reg <= wide_c;
            m_rate_reg <= rate_c;
            m_kind_reg <= res_kind;
            m_last_reg <= res_last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_kind_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {1'b0, m_rate_reg, (m_wide_reg ? BITS_WIDE : BITS_NARROW),
                       m_chan_reg, m_smp_reg};

endmodule

// ----- rtl/wpsp_checker.sv -----
`timescale 1ns / 1ps

module wpsp_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [wpsp_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                          m_tuser,
    input logic                          m_tlast
);
    import wpsp_pkg::*;

    // Sync reset empties the output register
    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // A stalled result holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("stalled result changed");

    // Error results carry a zero sample and never end the data chunk
    a_error_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == KIND_ERROR |->
            m_tdata[SMP_MSB:SMP_LSB] == 16'd0 && !m_tlast)
        else $error("error result with sample or last flag");

    // Format fields stay within what the parser accepts
    a_format_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[CHAN_MSB:CHAN_LSB] == 2'd1
                      || m_tdata[CHAN_MSB:CHAN_LSB] == 2'd2)
                     && (m_tdata[BITS_MSB:BITS_LSB] == BITS_NARROW
                      || m_tdata[BITS_MSB:BITS_LSB] == BITS_WIDE))
        else $error("illegal channel count or sample width");

endmodule

bind wave_pcm_stream_parser_top wpsp_checker u_wpsp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

// ----- verif/wave_pcm_stream_parser_top_test.sv -----
`timescale 1ns / 1ps

module wave_pcm_stream_parser_top_test;
    import wpsp_pkg::*;

    localparam int CYCLE_LIMIT  = 300_000;
    localparam int BYTE_TARGET  = 700;

    // One parser output as it appears on the master channel
    typedef struct packed {
        logic        kind;
        logic [15:0] smp;
        logic [1:0]  chans;
        logic [4:0]  bits;
        logic [31:0] rate;
        logic        last;
    } wave_output_t;

    // One row of the directed byte stream; want is used only when typed is set
    typedef struct packed {
        logic [7:0]   octet;
        logic         sof;
        logic         typed;
        wave_output_t want;
    } stim_row_t;

    // Flaws injected into generated files; clean files dominate
    typedef enum int {
        SHAPE_CLEAN,
        SHAPE_BAD_RIFF,
        SHAPE_BAD_WAVE,
        SHAPE_SMALL_RIFF,
        SHAPE_SHORT_FMT,
        SHAPE_BAD_CHANNELS,
        SHAPE_BAD_BITS,
        SHAPE_EMPTY_DATA,
        SHAPE_RAGGED,
        SHAPE_NOISE,
        SHAPE_FLIP,
        SHAPE_CUT
    } file_shape_t;

    localparam wave_output_t NO_OUTPUT = '0;
    // Error right after a restart: format fields still hold their reset values
    localparam wave_output_t FRESH_ERROR =
        '{KIND_ERROR, 16'h0000, 2'd1, BITS_NARROW, 32'h0, 1'b0};

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 s_tuser  = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tuser;
    logic                 m_tlast;

    // Parser state mirrored by the predictor
    phase_t      scan_phase;
    logic [2:0]  byte_slot;
    logic [31:0] shifter;
    logic [31:0] bytes_seen;
    logic [31:0] riff_len;
    logic [31:0] chunk_left;
    logic [1:0]  fmt_channels;
    logic        fmt_wide;
    logic [31:0] fmt_rate;
    logic [23:0] frame_bytes;

    wave_output_t wave_outputs_due [$];
    logic [7:0]   file_bytes [$];
    int           fail_count   = 0;
    int           cycle_count  = 0;
    int           sent_bytes   = 0;
    int           stall_left   = 0;
    bit           source_calm  = 1'b0;
    bit           sink_calm    = 1'b0;

    // Directed stream: a bad RIFF tag, then a file whose skipped chunk runs past
    // a zero RIFF size, then one stray byte that must be dropped.
    stim_row_t directed_rows [0:24] = '{
        '{8'h52, 1'b1, 1'b0, NO_OUTPUT},    // "R", start of file
        '{8'h49, 1'b0, 1'b0, NO_OUTPUT},    // "I"
        '{8'h46, 1'b0, 1'b0, NO_OUTPUT},    // "F"
        '{8'h00, 1'b0, 1'b1, FRESH_ERROR},  // tag reads "RIF\0"
        '{8'h52, 1'b1, 1'b0, NO_OUTPUT},    // "RIFF", restart
        '{8'h49, 1'b0, 1'b0, NO_OUTPUT},
        '{8'h46, 1'b0, 1'b0, NO_OUTPUT},
        '{8'h46, 1'b0, 1'b0, NO_OUTPUT},
        '{8'h00, 1'b0, 1'b0, NO_OUTPUT},    // RIFF size 0
        '{8'h00, 1'b0, 1'b0, NO_OUTPUT},
        '{8'h00, 1'b0, 1'b0, NO_OUTPUT},
        '{8'h00, 1'b0, 1'b0, NO_OUTPUT},
        '{8'h57, 1'b0, 1'b0, NO_OUTPUT},    // "WAVE"
        '{8'h41, 1'b0, 1'b0, NO_OUTPUT},
        '{8'h56, 1'b0, 1'b0, NO_OUTPUT},
        '{8'h45, 1'b0, 1'b0, NO_OUTPUT},
        '{8'h4A, 1'b0, 1'b0, NO_OUTPUT},    // "JUNK" chunk header
        '{8'h55, 1'b0, 1'b0, NO_OUTPUT},
        '{8'h4E, 1'b0, 1'b0, NO_OUTPUT},
        '{8'h4B, 1'b0, 1'b0, NO_OUTPUT},
        '{8'hFF, 1'b0, 1'b0, NO_OUTPUT},    // length 0xFFFFFFFF
        '{8'hFF, 1'b0, 1'b0, NO_OUTPUT},
        '{8'hFF, 1'b0, 1'b0, NO_OUTPUT},
        '{8'hFF, 1'b0, 1'b1, FRESH_ERROR},  // skip would overrun the RIFF size
        '{8'hA5, 1'b0, 1'b0, NO_OUTPUT}     // after an error: dropped
    };

    wave_pcm_stream_parser_top u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #1 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic void clear_parser();
        scan_phase   = PH_RIFF;
        byte_slot    = '0;
        shifter      = '0;
        bytes_seen   = '0;
        riff_len     = '0;
        chunk_left   = '0;
        fmt_channels = 2'd1;
        fmt_wide     = 1'b0;
        fmt_rate     = '0;
        frame_bytes  = '0;
    endfunction

    function automatic wave_output_t outcome(input logic kind, input logic [15:0] smp,
                                             input logic last);
        wave_output_t o;
        o.kind  = kind;
        o.smp   = smp;
        o.chans = fmt_channels;
        o.bits  = fmt_wide ? BITS_WIDE : BITS_NARROW;
        o.rate  = fmt_rate;
        o.last  = last;
        return o;
    endfunction

    // Park the parser until the next start of file
    function automatic wave_output_t error_output();
        scan_phase = PH_ERR;
        return outcome(KIND_ERROR, 16'h0000, 1'b0);
    endfunction

    // Fold one frame down to a mono sample
    function automatic logic [15:0] mix_sample(input logic [7:0] b0, input logic [7:0] b1,
                                               input logic [7:0] b2, input logic [7:0] b3);
        int v;
        int left;
        int right;
        if (!fmt_wide) begin
            if (fmt_channels == 2'd2) begin
                v = ((int'(b0) - 128) + (int'(b1) - 128)) * 128;
            end else begin
                v = (int'(b0) - 128) * 257;
                if (v < -32768) v = -32768;
            end
        end else if (fmt_channels == 2'd2) begin
            left  = $signed({b1, b0});
            right = $signed({b3, b2});
            v     = left / 2 + right / 2;     // each half truncates toward zero
        end else begin
            v = $signed({b1, b0});
        end
        return v[15:0];
    endfunction

    // Advance the mirrored parser by one file byte; return 1 when it emits
    function automatic bit parse_wave_byte(input logic [7:0] b, input logic sof,
                                           output wave_output_t out);
        logic [31:0] word;
        logic [31:0] wanted;
        logic [2:0]  c;
        int          need;
        out = NO_OUTPUT;
        if (sof) clear_parser();
        if (bytes_seen != OFFSET_MAX) bytes_seen++;

        case (scan_phase)
            PH_RIFF, PH_SIZE, PH_WAVE, PH_FMT_A, PH_FMT_RATE, PH_FMT_B, PH_FMT_C: begin
                shifter = {b, shifter[31:8]};
                byte_slot++;
                if (byte_slot < 3'd4) return 1'b0;
                byte_slot = '0;
                word      = shifter;
                case (scan_phase)
                    PH_RIFF: begin
                        if (word != TAG_RIFF) begin
                            out = error_output();
                            return 1'b1;
                        end
                        scan_phase = PH_SIZE;
                    end
                    PH_SIZE: begin
                        riff_len   = word;
                        scan_phase = PH_WAVE;
                    end
                    PH_WAVE: begin
                        if (word != TAG_WAVE) begin
                            out = error_output();
                            return 1'b1;
                        end
                        scan_phase = PH_HDR_FMT;
                    end
                    PH_FMT_A: begin
                        // format code in the low half is not checked
                        if (word[31:16] != 16'd1 && word[31:16] != 16'd2) begin
                            out = error_output();
                            return 1'b1;
                        end
                        fmt_channels = word[17:16];
                        scan_phase   = PH_FMT_RATE;
                    end
                    PH_FMT_RATE: begin
                        fmt_rate   = word;
                        scan_phase = PH_FMT_B;
                    end
                    PH_FMT_B: begin
                        scan_phase = PH_FMT_C;
                    end
                    default: begin
                        if (word[31:16] == 16'd8) begin
                            fmt_wide = 1'b0;
                        end else if (word[31:16] == 16'd16) begin
                            fmt_wide = 1'b1;
                        end else begin
                            out = error_output();
                            return 1'b1;
                        end
                        scan_phase = (chunk_left == 0) ? PH_HDR_DATA : PH_FMT_TAIL;
                    end
                endcase
                return 1'b0;
            end
            PH_HDR_FMT, PH_HDR_DATA: begin
                shifter   = {b, shifter[31:8]};
                c         = byte_slot;
                byte_slot = c + 3'd1;
                if (c == 3'd3) begin
                    chunk_left = shifter;       // hold the tag until the length is in
                    return 1'b0;
                end
                if (c != 3'd7) return 1'b0;
                byte_slot = '0;
                wanted    = (scan_phase == PH_HDR_FMT) ? TAG_FMT : TAG_DATA;
                if (chunk_left == wanted) begin
                    // wanted chunks bypass the RIFF size check
                    if (scan_phase == PH_HDR_FMT) begin
                        if (shifter < FMT_MIN_LEN) begin
                            out = error_output();
                            return 1'b1;
                        end
                        chunk_left = shifter - FMT_MIN_LEN;
                        scan_phase = PH_FMT_A;
                    end else begin
                        chunk_left  = shifter;
                        frame_bytes = '0;
                        scan_phase  = (shifter == 0) ? PH_DONE : PH_DATA;
                    end
                    return 1'b0;
                end
                if ({1'b0, bytes_seen} + {1'b0, shifter} >= {1'b0, riff_len}) begin
                    out = error_output();
                    return 1'b1;
                end
                chunk_left = shifter;
                if (shifter != 0)
                    scan_phase = (scan_phase == PH_HDR_FMT) ? PH_SKIP_FMT : PH_SKIP_DATA;
                return 1'b0;
            end
            PH_SKIP_FMT, PH_SKIP_DATA, PH_FMT_TAIL: begin
                chunk_left--;
                if (chunk_left == 0)
                    scan_phase = (scan_phase == PH_SKIP_FMT) ? PH_HDR_FMT : PH_HDR_DATA;
                return 1'b0;
            end
            PH_DATA: begin
                need = (fmt_channels == 2'd2 ? 2 : 1) * (fmt_wide ? 2 : 1);
                c    = byte_slot;
                chunk_left--;
                if (int'(c) + 1 >= need) begin
                    byte_slot = '0;
                    if (chunk_left == 0) scan_phase = PH_DONE;
                    out = outcome(KIND_SAMPLE,
                                  mix_sample(c == 3'd0 ? b : frame_bytes[7:0],
                                             c == 3'd1 ? b : frame_bytes[15:8],
                                             c == 3'd2 ? b : frame_bytes[23:16],
                                             b),
                                  chunk_left == 0);
                    return 1'b1;
                end
                if (c == 3'd0) frame_bytes = {16'h0000, b};
                else frame_bytes[8*c +: 8] = b;
                byte_slot = c + 3'd1;
                // data ran out inside a frame
                if (chunk_left == 0) begin
                    out = error_output();
                    return 1'b1;
                end
                return 1'b0;
            end
            default: return 1'b0;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // File generator
    // ------------------------------------------------------------------

    function automatic void put_u16(input logic [15:0] v);
        file_bytes.push_back(v[7:0]);
        file_bytes.push_back(v[15:8]);
    endfunction

    function automatic void put_u32(input logic [31:0] v);
        put_u16(v[15:0]);
        put_u16(v[31:16]);
    endfunction

    // Bias sample bytes toward the code extremes
    function automatic logic [7:0] sample_octet();
        case ($urandom_range(0, 11))
            0: return 8'h00;
            1: return 8'h7F;
            2: return 8'h80;
            3: return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    // Short chunk the parser must skip; before fmt it may carry the data tag,
    // after fmt it may carry the fmt tag
    function automatic void add_filler_chunk(input bit before_fmt);
        logic [31:0] tag;
        int          len;
        tag = $urandom;
        if (tag == TAG_FMT || tag == TAG_DATA) tag ^= 32'h1;
        if ($urandom_range(0, 2) == 0) tag = before_fmt ? TAG_DATA : TAG_FMT;
        len = $urandom_range(0, 6);
        put_u32(tag);
        put_u32(len);
        repeat (len) file_bytes.push_back(8'($urandom));
    endfunction

    // Build one file into file_bytes; idx rotates through the four sample modes
    function automatic void build_file(input int idx);
        file_shape_t shape;
        logic        stereo;
        logic        wide;
        int          frame;
        int          len;
        int          pick;
        logic [15:0] chan_field;
        logic [15:0] bits_field;
        file_bytes.delete();
        stereo = idx[0];
        wide   = idx[1];
        if ($urandom_range(0, 9) < 7) shape = SHAPE_CLEAN;
        else shape = file_shape_t'($urandom_range(SHAPE_BAD_RIFF, SHAPE_CUT));

        if (shape == SHAPE_NOISE) begin
            if ($urandom_range(0, 1) == 1) put_u32(TAG_RIFF);
            repeat ($urandom_range(4, 30)) file_bytes.push_back(8'($urandom));
            return;
        end

        put_u32(shape == SHAPE_BAD_RIFF ? $urandom : TAG_RIFF);
        if (shape == SHAPE_SMALL_RIFF) begin
            put_u32($urandom_range(0, 40));
        end else begin
            case ($urandom_range(0, 3))
                0: put_u32(32'hFFFF_FFFF);
                1: put_u32($urandom | 32'h0001_0000);
                2: put_u32($urandom_range(0, 40));
                default: put_u32(32'h0000_1000 + $urandom_range(0, 32'hFFFF));
            endcase
        end
        put_u32(shape == SHAPE_BAD_WAVE ? $urandom : TAG_WAVE);
        repeat (shape == SHAPE_SMALL_RIFF ? 1 : $urandom_range(0, 2)) add_filler_chunk(1'b1);

        // format chunk
        if (shape == SHAPE_SHORT_FMT) len = $urandom_range(0, 15);
        else len = 16 + ($urandom_range(0, 3) == 0 ? $urandom_range(1, 4) : 0);
        put_u32(TAG_FMT);
        put_u32(len);
        put_u16($urandom_range(0, 3) == 0 ? 16'($urandom) : 16'd1);
        chan_field = stereo ? 16'd2 : 16'd1;
        if (shape == SHAPE_BAD_CHANNELS) begin
            case ($urandom_range(0, 2))
                0: chan_field = 16'd0;
                1: chan_field = 16'd3;
                default: chan_field = 16'($urandom_range(4, 65535));
            endcase
        end
        put_u16(chan_field);
        case ($urandom_range(0, 5))
            0: put_u32(32'h0);
            1: put_u32(32'hFFFF_FFFF);
            2: put_u32(32'd44100);
            default: put_u32($urandom);
        endcase
        put_u32($urandom);
        put_u16(16'($urandom));
        bits_field = wide ? 16'd16 : 16'd8;
        if (shape == SHAPE_BAD_BITS) begin
            case ($urandom_range(0, 3))
                0: bits_field = 16'd0;
                1: bits_field = 16'd12;
                2: bits_field = 16'd24;
                default: bits_field = 16'($urandom_range(17, 65535));
            endcase
        end
        put_u16(bits_field);
        repeat (len > 16 ? len - 16 : 0) file_bytes.push_back(8'($urandom));
        repeat ($urandom_range(0, 1)) add_filler_chunk(1'b0);

        // data chunk
        frame = (stereo ? 2 : 1) * (wide ? 2 : 1);
        if ($urandom_range(0, 7) == 0) len = frame * $urandom_range(13, 24);
        else len = frame * $urandom_range(1, 12);
        if (shape == SHAPE_EMPTY_DATA) len = 0;
        if (shape == SHAPE_RAGGED && frame > 1) len += $urandom_range(1, frame - 1);
        put_u32(TAG_DATA);
        put_u32(len);
        repeat (len) file_bytes.push_back(sample_octet());
        // trailing bytes past the data chunk are dropped by the parser
        repeat ($urandom_range(0, 2) == 0 ? $urandom_range(1, 4) : 0)
            file_bytes.push_back(8'($urandom));

        if (shape == SHAPE_FLIP) begin
            pick = $urandom_range(0, file_bytes.size() - 1);
            file_bytes[pick] ^= 8'($urandom_range(1, 255));
        end
        if (shape == SHAPE_CUT) begin
            pick = $urandom_range(1, file_bytes.size() - 1);
            while (file_bytes.size() > pick) void'(file_bytes.pop_back());
        end
    endfunction

    // Mostly zero, often a short gap, now and then a long pause
    function automatic int pick_gap(input bit calm);
        int roll;
        if (calm) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // ------------------------------------------------------------------
    // Source side: drive at the falling edge, detect the transfer at the rising
    // edge. Called at a falling edge and returns at a falling edge. s_tvalid is
    // lowered only when a gap follows, so it never toggles twice in one step.
    // ------------------------------------------------------------------
    task automatic feed_byte(input logic [7:0] octet, input logic sof, input bit typed,
                             input wave_output_t typed_out);
        int           gap;
        bit           emits;
        wave_output_t predicted;
        gap = pick_gap(source_calm);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= octet;
        s_tuser  <= sof;
        do @(posedge aclk); while (!s_tready);
        sent_bytes++;
        emits = parse_wave_byte(octet, sof, predicted);
        if (typed) wave_outputs_due.push_back(typed_out);
        else if (emits) wave_outputs_due.push_back(predicted);
        @(negedge aclk);
    endtask

    // ------------------------------------------------------------------
    // Sink side: random backpressure, with calm stretches
    // ------------------------------------------------------------------
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left--;
        end else begin
            stall_left = pick_gap(sink_calm);
            if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else begin
                m_tready <= 1'b1;
            end
        end
        if ($urandom_range(0, 127) == 0) sink_calm = !sink_calm;
    end

    function automatic void check_field(input string field, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h",
                     $time, field, want, got);
            fail_count++;
        end
    endfunction

    // Compare each result transfer with the oldest prediction
    always @(posedge aclk) begin
        wave_output_t got;
        wave_output_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.kind  = m_tuser;
            got.smp   = m_tdata[SMP_MSB:SMP_LSB];
            got.chans = m_tdata[CHAN_MSB:CHAN_LSB];
            got.bits  = m_tdata[BITS_MSB:BITS_LSB];
            got.rate  = m_tdata[RATE_MSB:RATE_LSB];
            got.last  = m_tlast;
            if (wave_outputs_due.size() == 0) begin
                $display("%0t: result with none pending, expected nothing, %s",
                         $time, $sformatf("got kind %0d sample 0x%0h", got.kind, got.smp));
                fail_count++;
            end else begin
                want = wave_outputs_due.pop_front();
                check_field("result_kind", want.kind, got.kind);
                check_field("sample_value", want.smp, got.smp);
                check_field("channel_count", want.chans, got.chans);
                check_field("bits_per_sample", want.bits, got.bits);
                check_field("sample_rate", want.rate, got.rate);
                check_field("last_sample", want.last, got.last);
            end
        end
    end

    // Watchdog: end a hung run
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        int file_idx;
        clear_parser();
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (directed_rows[i])
            feed_byte(directed_rows[i].octet, directed_rows[i].sof,
                      directed_rows[i].typed, directed_rows[i].want);

        // Random files; now and then drop the start flag so a file runs on
        // into whatever state the previous one left
        file_idx = 0;
        while (sent_bytes < BYTE_TARGET) begin
            build_file(file_idx);
            if ($urandom_range(0, 3) == 0) source_calm = !source_calm;
            foreach (file_bytes[i])
                feed_byte(file_bytes[i], i == 0 && $urandom_range(0, 29) != 0,
                          1'b0, NO_OUTPUT);
            file_idx++;
        end
        s_tvalid <= 1'b0;

        // Drain, then wait on so that stray results would still be seen
        while (wave_outputs_due.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
